@@ src/utee_pkg.sv @@
// Shared types, constants and entry helpers for the unrooted tree edit engine.
package utee_pkg;

   localparam int CMD_W     = 2;
   localparam int NODE_IN_W = 7;
   localparam int NODE_W    = 8;
   localparam int ENTRY_W   = 3 * NODE_W;
   localparam int STATUS_W  = 2;

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   localparam node_type                NONE_NODE      = 8'hFF;
   localparam entry_type               NONE_ENTRY     = {3{NONE_NODE}};
   localparam logic [NODE_IN_W-1:0]    NUM_TAXA_RESET = 7'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT       = 2'd0,
      CMD_INSERT     = 2'd1,
      CMD_DISCONNECT = 2'd2,
      CMD_READ       = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK            = 2'd0,
      STAT_EMPTY         = 2'd1,
      STAT_NOT_NEIGHBOUR = 2'd2,
      STAT_FREED_TAXON   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_A,
      ST_INIT_B,
      ST_INS_FAIL,
      ST_INS_A,
      ST_INS_B,
      ST_INS_N,
      ST_INS_T,
      ST_DIS_T,
      ST_DIS_P,
      ST_DIS_R0,
      ST_DIS_R1,
      ST_READ
   } seq_state_type;

   typedef struct packed {
      logic     en;
      node_type node;
   } adj_rd_type;

   typedef struct packed {
      logic      en;
      node_type  node;
      entry_type data;
   } adj_wr_type;

   typedef struct packed {
      logic     init;
      logic     pop;
      logic     push;
      node_type push_node;
   } stk_ctrl_type;

   typedef struct packed {
      logic     empty;
      node_type pop_node;
   } stk_stat_type;

   // slot 0 sits in the low byte
   function automatic entry_type make_entry(node_type s0, node_type s1, node_type s2);
      return {s2, s1, s0};
   endfunction

   function automatic entry_type replace_first(entry_type e, node_type old_v,
                                               node_type new_v);
      entry_type r;
      r = e;
      if (e[7:0] == old_v) begin
         r[7:0] = new_v;
      end else if (e[15:8] == old_v) begin
         r[15:8] = new_v;
      end else if (e[23:16] == old_v) begin
         r[23:16] = new_v;
      end
      return r;
   endfunction

endpackage

@@ src/utee_req_if.sv @@
// Command channel: valid/ready handshake with the command beat payload.
interface utee_req_if;
   import utee_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [NODE_IN_W-1:0] node_a;
   logic [NODE_IN_W-1:0] node_b;
   logic [NODE_IN_W-1:0] target_node;

   modport source (output valid, output command, output node_a, output node_b,
                   output target_node, input ready);
   modport sink (input valid, input command, input node_a, input node_b,
                 input target_node, output ready);
endinterface

@@ src/utee_rsp_if.sv @@
// Result channel: valid/ready handshake with the result beat payload.
interface utee_rsp_if;
   import utee_pkg::*;

   logic                valid;
   logic                ready;
   logic [NODE_W-1:0]   touched_node;
   logic [NODE_W-1:0]   neighbour_zero;
   logic [NODE_W-1:0]   neighbour_one;
   logic [NODE_W-1:0]   neighbour_two;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output touched_node, output neighbour_zero,
                   output neighbour_one, output neighbour_two, output status,
                   input ready);
   modport sink (input valid, input touched_node, input neighbour_zero,
                 input neighbour_one, input neighbour_two, input status,
                 output ready);
endinterface

@@ src/utee_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module utee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ src/utee_adj_store.sv @@
// Adjacency store: node entry RAM with per-node valid bits and write-to-read forwarding.
module utee_adj_store #(
   parameter int NODE_SLOTS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  utee_pkg::adj_rd_type  rd,
   input  utee_pkg::adj_wr_type  wr,
   output utee_pkg::entry_type   entry
);
   import utee_pkg::*;

   localparam int       IDX_W      = $clog2(NODE_SLOTS);
   localparam node_type SLOT_LIMIT = NODE_W'(NODE_SLOTS);

   logic [NODE_SLOTS-1:0] valid_ff, valid_in;
   logic                  vld_ff, vld_in;
   logic                  fwd_ff, fwd_in;
   entry_type             fwd_data_ff, fwd_data_in;
   entry_type             ram_q;
   logic                  wr_ok;
   logic                  rd_ok;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      rd_addr;

   assign wr_ok   = wr.en && (wr.node < SLOT_LIMIT);
   assign rd_ok   = rd.node < SLOT_LIMIT;
   assign wr_addr = wr.node[IDX_W-1:0];
   assign rd_addr = rd.node[IDX_W-1:0];

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end
      if (wr_ok) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // same-cycle write to the entry being read: take the new data
   always_comb begin
      vld_in      = vld_ff;
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (rd.en) begin
         vld_in      = rd_ok && valid_ff[rd_addr];
         fwd_in      = wr_ok && (rd.node == wr.node);
         fwd_data_in = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_ff   <= 1'b0;
         fwd_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         vld_ff   <= vld_in;
         fwd_ff   <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= fwd_data_in;
   end

   utee_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (wr_ok),
      .waddr (wr_addr),
      .wdata (wr.data),
      .re    (rd.en),
      .raddr (rd_addr),
      .rdata (ram_q)
   );

   assign entry = fwd_ff ? fwd_data_ff : (vld_ff ? ram_q : NONE_ENTRY);

   a_fwd_hit: assert property (@(posedge clock) disable iff (reset)
      rd.en && wr_ok && (rd.node == wr.node) |=> entry == $past(wr.data))
      else $error("adjacency forwarding lost a same-cycle write");

   a_clear_none: assert property (@(posedge clock) disable iff (reset)
      clear && !wr.en |=> valid_ff == '0)
      else $error("table clear left a valid entry");

   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      rd.en && !rd_ok |=> entry == NONE_ENTRY)
      else $error("read beyond the node table did not return none");
endmodule

@@ src/utee_free_stack.sv @@
// Free inner-node stack: RAM plus count, with an init watermark for the refilled entries.
module utee_free_stack #(
   parameter int NODE_SLOTS = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [utee_pkg::NODE_IN_W-1:0]      num_taxa,
   input  utee_pkg::stk_ctrl_type              ctrl,
   output utee_pkg::stk_stat_type              stat
);
   import utee_pkg::*;

   localparam int               IDX_W  = $clog2(NODE_SLOTS);
   localparam int               CNT_W  = $clog2(NODE_SLOTS + 1);
   localparam logic [CNT_W-1:0] FULL   = CNT_W'(NODE_SLOTS);
   localparam logic [8:0]       SLOTS9 = 9'(NODE_SLOTS);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     lowmark_ff, lowmark_in;
   logic [NODE_IN_W-1:0] base_ff, base_in;
   logic                 pop_init_ff, pop_init_in;
   node_type             pop_val_ff, pop_val_in;
   logic [CNT_W-1:0]     top_idx;
   logic                 push_ok;
   logic [8:0]           taxa9;
   logic [8:0]           alloc_raw;
   logic [8:0]           alloc_cap;
   logic [8:0]           fill;
   logic [IDX_W-1:0]     ram_q;

   assign taxa9     = 9'(num_taxa);
   assign alloc_raw = (num_taxa == '0) ? 9'd0 : (taxa9 << 1) - 9'd2;
   assign alloc_cap = (alloc_raw > SLOTS9) ? SLOTS9 : alloc_raw;
   assign fill      = (alloc_cap > taxa9) ? alloc_cap - taxa9 : 9'd0;

   assign top_idx = count_ff - 1'b1;
   assign push_ok = ctrl.push && (count_ff != FULL);

   // entries below the watermark still hold base + index from the last init
   always_comb begin
      count_in    = count_ff;
      lowmark_in  = lowmark_ff;
      base_in     = base_ff;
      pop_init_in = pop_init_ff;
      pop_val_in  = pop_val_ff;
      if (ctrl.init) begin
         count_in   = CNT_W'(fill);
         lowmark_in = FULL;
         base_in    = num_taxa;
      end else if (ctrl.pop) begin
         count_in    = top_idx;
         pop_init_in = top_idx < lowmark_ff;
         pop_val_in  = NODE_W'(base_ff) + NODE_W'(top_idx);
      end else if (push_ok) begin
         count_in = count_ff + 1'b1;
         if (count_ff < lowmark_ff) begin
            lowmark_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         lowmark_ff  <= '0;
         base_ff     <= '0;
         pop_init_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         lowmark_ff  <= lowmark_in;
         base_ff     <= base_in;
         pop_init_ff <= pop_init_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_val_ff <= pop_val_in;
   end

   utee_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NODE_SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (push_ok),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (ctrl.push_node[IDX_W-1:0]),
      .re    (ctrl.pop),
      .raddr (top_idx[IDX_W-1:0]),
      .rdata (ram_q)
   );

   assign stat.empty    = (count_ff == '0);
   assign stat.pop_node = pop_init_ff ? pop_val_ff : NODE_W'(ram_q);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("free count beyond stack depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> count_ff != '0)
      else $error("pop from an empty free stack");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.pop && ctrl.push) && !(ctrl.init && (ctrl.pop || ctrl.push)))
      else $error("conflicting free stack operations");
endmodule

@@ src/unrooted_tree_edit_engine_unit.sv @@
// Unrooted tree edit engine top level: command sequencer and result register.
// Insert answers with an empty-stack status when the free stack is empty, and disconnect
// ends early with a not-neighbour status when the target is not a neighbour of its parent.
// One command at a time; the next beat is taken the cycle the sequencer is back in idle,
// and a command's last state waits while an unaccepted result still holds the result register.
// Synchronous reset: all table slots read as none, free stack empty, num_taxa = 2.
module unrooted_tree_edit_engine_unit #(
   parameter int NODE_SLOTS = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   utee_req_if.sink                       req_chan,
   utee_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [utee_pkg::NODE_IN_W-1:0] csr_wr_data
);
   import utee_pkg::*;

   seq_state_type        state_ff, state_in;
   logic [NODE_IN_W-1:0] num_taxa_ff, num_taxa_in;
   logic [NODE_IN_W-1:0] a_ff, a_in;
   logic [NODE_IN_W-1:0] b_ff, b_in;
   logic [NODE_IN_W-1:0] t_ff, t_in;
   node_type             n_ff, n_in;
   node_type             p_ff, p_in;
   node_type             r0_ff, r0_in;
   node_type             r1_ff, r1_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   node_type             touched_ff, touched_in;
   entry_type            nb_ff, nb_in;
   status_type           status_ff, status_in;

   logic                 req_ready;
   logic                 out_free;
   logic                 res_load;
   node_type             res_touched;
   entry_type            res_nb;
   status_type           res_status;

   logic                 adj_clear;
   adj_rd_type           adj_rd;
   adj_wr_type           adj_wr;
   entry_type            adj_entry;
   stk_ctrl_type         stk_ctrl;
   stk_stat_type         stk_stat;

   node_type             a_node, b_node, t_node;
   logic                 dis_found;
   node_type             dis_r0, dis_r1;

   assign a_node   = NODE_W'(a_ff);
   assign b_node   = NODE_W'(b_ff);
   assign t_node   = NODE_W'(t_ff);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // position of the target among the parent's slots picks the two remaining neighbours
   always_comb begin
      dis_found = 1'b1;
      dis_r0    = adj_entry[15:8];
      dis_r1    = adj_entry[23:16];
      priority if (adj_entry[7:0] == t_node) begin
         dis_r0 = adj_entry[15:8];
         dis_r1 = adj_entry[23:16];
      end else if (adj_entry[15:8] == t_node) begin
         dis_r0 = adj_entry[7:0];
         dis_r1 = adj_entry[23:16];
      end else if (adj_entry[23:16] == t_node) begin
         dis_r0 = adj_entry[7:0];
         dis_r1 = adj_entry[15:8];
      end else begin
         dis_found = 1'b0;
      end
   end

   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      t_in        = t_ff;
      n_in        = n_ff;
      p_in        = p_ff;
      r0_in       = r0_ff;
      r1_in       = r1_ff;
      req_ready   = 1'b0;
      adj_clear   = 1'b0;
      adj_rd      = '0;
      adj_wr      = '0;
      stk_ctrl    = '0;
      res_load    = 1'b0;
      res_touched = NONE_NODE;
      res_nb      = NONE_ENTRY;
      res_status  = STAT_OK;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               a_in = req_chan.node_a;
               b_in = req_chan.node_b;
               t_in = req_chan.target_node;
               unique case (cmd_type'(req_chan.command))
                  CMD_INIT: begin
                     adj_clear     = 1'b1;
                     stk_ctrl.init = 1'b1;
                     state_in      = ST_INIT_A;
                  end
                  CMD_INSERT: begin
                     if (stk_stat.empty) begin
                        state_in = ST_INS_FAIL;
                     end else begin
                        stk_ctrl.pop = 1'b1;
                        adj_rd.en    = 1'b1;
                        adj_rd.node  = NODE_W'(req_chan.node_a);
                        state_in     = ST_INS_A;
                     end
                  end
                  CMD_DISCONNECT: begin
                     adj_rd.en   = 1'b1;
                     adj_rd.node = NODE_W'(req_chan.target_node);
                     state_in    = ST_DIS_T;
                  end
                  CMD_READ: begin
                     adj_rd.en   = 1'b1;
                     adj_rd.node = NODE_W'(req_chan.target_node);
                     state_in    = ST_READ;
                  end
               endcase
            end
         end
         ST_INIT_A: begin
            adj_wr.en   = 1'b1;
            adj_wr.node = a_node;
            adj_wr.data = make_entry(b_node, NONE_NODE, NONE_NODE);
            state_in    = ST_INIT_B;
         end
         ST_INIT_B: begin
            if (out_free) begin
               adj_wr.en   = 1'b1;
               adj_wr.node = b_node;
               adj_wr.data = make_entry(a_node, NONE_NODE, NONE_NODE);
               res_load    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_INS_FAIL: begin
            if (out_free) begin
               res_load   = 1'b1;
               res_status = STAT_EMPTY;
               state_in   = ST_IDLE;
            end
         end
         ST_INS_A: begin
            n_in        = stk_stat.pop_node;
            adj_wr.en   = 1'b1;
            adj_wr.node = a_node;
            adj_wr.data = replace_first(adj_entry, b_node, stk_stat.pop_node);
            adj_rd.en   = 1'b1;
            adj_rd.node = b_node;
            state_in    = ST_INS_B;
         end
         ST_INS_B: begin
            adj_wr.en   = 1'b1;
            adj_wr.node = b_node;
            adj_wr.data = replace_first(adj_entry, a_node, n_ff);
            state_in    = ST_INS_N;
         end
         ST_INS_N: begin
            adj_wr.en   = 1'b1;
            adj_wr.node = n_ff;
            adj_wr.data = make_entry(a_node, b_node, t_node);
            adj_rd.en   = 1'b1;
            adj_rd.node = t_node;
            state_in    = ST_INS_T;
         end
         ST_INS_T: begin
            if (out_free) begin
               adj_wr.en   = 1'b1;
               adj_wr.node = t_node;
               adj_wr.data = (t_ff < num_taxa_ff) ?
                             make_entry(n_ff, NONE_NODE, NONE_NODE) :
                             {adj_entry[23:8], n_ff};
               res_load    = 1'b1;
               res_touched = n_ff;
               state_in    = ST_IDLE;
            end
         end
         ST_DIS_T: begin
            p_in        = adj_entry[7:0];
            adj_rd.en   = 1'b1;
            adj_rd.node = adj_entry[7:0];
            state_in    = ST_DIS_P;
         end
         ST_DIS_P: begin
            if (dis_found) begin
               r0_in       = dis_r0;
               r1_in       = dis_r1;
               adj_rd.en   = 1'b1;
               adj_rd.node = dis_r0;
               state_in    = ST_DIS_R0;
            end else if (out_free) begin
               res_load   = 1'b1;
               res_status = STAT_NOT_NEIGHBOUR;
               state_in   = ST_IDLE;
            end
         end
         ST_DIS_R0: begin
            adj_wr.en   = 1'b1;
            adj_wr.node = r0_ff;
            adj_wr.data = replace_first(adj_entry, p_ff, r1_ff);
            adj_rd.en   = 1'b1;
            adj_rd.node = r1_ff;
            state_in    = ST_DIS_R1;
         end
         ST_DIS_R1: begin
            if (out_free) begin
               adj_wr.en          = 1'b1;
               adj_wr.node        = r1_ff;
               adj_wr.data        = replace_first(adj_entry, p_ff, r0_ff);
               stk_ctrl.push      = 1'b1;
               stk_ctrl.push_node = p_ff;
               res_load           = 1'b1;
               res_touched        = p_ff;
               res_status         = (p_ff < NODE_W'(num_taxa_ff)) ? STAT_FREED_TAXON : STAT_OK;
               state_in           = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               res_load = 1'b1;
               res_nb   = adj_entry;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      num_taxa_in  = csr_wr_en ? csr_wr_data : num_taxa_ff;
      rsp_valid_in = res_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      touched_in   = res_load ? res_touched : touched_ff;
      nb_in        = res_load ? res_nb : nb_ff;
      status_in    = res_load ? res_status : status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_taxa_ff  <= NUM_TAXA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_taxa_ff  <= num_taxa_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      t_ff       <= t_in;
      n_ff       <= n_in;
      p_ff       <= p_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      touched_ff <= touched_in;
      nb_ff      <= nb_in;
      status_ff  <= status_in;
   end

   utee_adj_store #(
      .NODE_SLOTS (NODE_SLOTS)
   ) u_adj_store (
      .clock (clock),
      .reset (reset),
      .clear (adj_clear),
      .rd    (adj_rd),
      .wr    (adj_wr),
      .entry (adj_entry)
   );

   utee_free_stack #(
      .NODE_SLOTS (NODE_SLOTS)
   ) u_free_stack (
      .clock    (clock),
      .reset    (reset),
      .num_taxa (num_taxa_ff),
      .ctrl     (stk_ctrl),
      .stat     (stk_stat)
   );

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.touched_node   = touched_ff;
   assign rsp_chan.neighbour_zero = nb_ff[7:0];
   assign rsp_chan.neighbour_one  = nb_ff[15:8];
   assign rsp_chan.neighbour_two  = nb_ff[23:16];
   assign rsp_chan.status         = status_ff;

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff != ST_IDLE)
      else $error("command beat taken without leaving idle");

   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> state_ff == ST_IDLE)
      else $error("result raised while the sequencer is still busy");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STAT_EMPTY |-> touched_ff == NONE_NODE)
      else $error("empty stack result names a node");

   a_touch_no_nb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && touched_ff != NONE_NODE |-> nb_ff == NONE_ENTRY)
      else $error("edit result carries neighbour slots");
endmodule
